// ----- hdl/wwpc_pkg.sv -----
// Shared types, constants and helpers of the whole-word paragraph counter.
package wwpc_pkg;

	localparam int MAX_TARGET_LEN_DEF = 16;
	localparam int COUNT_WIDTH_DEF    = 16;
	localparam int TARGET_BYTES       = 16;
	localparam int OUT_WIDTH          = 16;
	localparam int CFG_INDEX_WIDTH    = 2;
	localparam int CFG_DATA_WIDTH     = 64;
	localparam int LEN_REG_WIDTH      = 5;
	localparam int FIFO_DEPTH         = 8;
	localparam int FIFO_AW            = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW            = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CHAR_NL      = 8'h0A;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_TARGET_LOW  = 2'd0,
		REG_TARGET_HIGH = 2'd1,
		REG_TARGET_LEN  = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic hit_next;
		logic hit_end;
	} match_t;

	typedef struct packed {
		logic [OUT_WIDTH-1:0] paragraph_number;
		logic [OUT_WIDTH-1:0] hit_count;
		logic                 is_file_total;
		logic                 last_result;
	} result_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
			(c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
	endfunction

endpackage

// ----- hdl/wwpc_match.sv -----
// Whole-word match detection over the byte window for every target length.
module wwpc_match import wwpc_pkg::*; #(
	parameter int MAX_TARGET_LEN = MAX_TARGET_LEN_DEF,
	localparam int WD = MAX_TARGET_LEN + 1,
	localparam int SW = $clog2(WD + 1),
	localparam int LW = $clog2(MAX_TARGET_LEN + 1)
) (
	input  logic [WD-1:0][7:0]           window,
	input  logic [7:0]                   cur_byte,
	input  logic [SW-1:0]                seen,
	input  logic [LW-1:0]                len,
	input  logic [TARGET_BYTES-1:0][7:0] target,
	output match_t                       match
);

	logic [MAX_TARGET_LEN:0] hit_next_vec;
	logic [MAX_TARGET_LEN:0] hit_end_vec;

	assign hit_next_vec[0] = 1'b0;
	assign hit_end_vec[0]  = 1'b0;

	for (genvar L = 1; L <= MAX_TARGET_LEN; L++) begin : g_len
		logic eq_next;
		logic eq_end;

		// A match followed by the current byte sits in window[L-1:0]; one that
		// ends on the current byte has its last byte in cur_byte.
		always_comb begin
			eq_next = 1'b1;
			eq_end  = (cur_byte == target[L-1]);
			for (int i = 0; i < L; i++) begin
				eq_next = eq_next && (window[L-1-i] == target[i]);
			end
			for (int i = 0; i < L - 1; i++) begin
				eq_end = eq_end && (window[L-2-i] == target[i]);
			end
		end

		assign hit_next_vec[L] = eq_next && (seen >= SW'(L)) &&
			!((seen > SW'(L)) && is_letter(window[L])) && !is_letter(cur_byte);
		assign hit_end_vec[L] = eq_end && (seen >= SW'(L - 1)) &&
			!((seen >= SW'(L)) && is_letter(window[L-1]));
	end

	assign match.hit_next = hit_next_vec[len];
	assign match.hit_end  = hit_end_vec[len];

endmodule

// ----- hdl/wwpc_fifo.sv -----
// Result queue that takes up to two results per cycle and hands out one.
module wwpc_fifo import wwpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push0,
	input  result_t            push_data0,
	input  logic               push1,
	input  result_t            push_data1,
	input  logic               pop,
	output result_t            head,
	output logic               not_empty,
	output logic [FIFO_CW-1:0] count
);

	result_t              mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 do_pop;
	logic [FIFO_CW-1:0]   n_push;

	assign do_pop    = pop && (count_q != '0);
	assign n_push    = FIFO_CW'({1'b0, push0} + {1'b0, push1});
	assign head      = mem[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push0) begin
			mem[wr_ptr_q] <= push_data0;
		end
		if (push1) begin
			mem[FIFO_AW'(wr_ptr_q + 1'b1)] <= push_data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= FIFO_AW'(wr_ptr_q + n_push);
			if (do_pop) begin
				rd_ptr_q <= FIFO_AW'(rd_ptr_q + 1'b1);
			end
			count_q <= FIFO_CW'(count_q + n_push - {{(FIFO_CW-1){1'b0}}, do_pop});
		end
	end

endmodule

// ----- hdl/whole_word_paragraph_counter_unit.sv -----
// Top level of the whole-word paragraph counter.
// Flow: an accepted byte is registered in the input stage, then counted, and its results
// are written to the result queue, from which they are offered on the output.
// Throughput: one byte per cycle; input waits only while the eight-entry result queue
// lacks room for two results per byte in flight. A final byte gives up to two results.
// Reset: arst_n clears the window, counts and queue at once; the target registers
// return to zero bytes with length one. After a final byte the counting state clears.
module whole_word_paragraph_counter_unit import wwpc_pkg::*; #(
	parameter int MAX_TARGET_LEN = MAX_TARGET_LEN_DEF,
	parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 text_byte,
	input  logic                       end_of_text,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [OUT_WIDTH-1:0]       paragraph_number,
	output logic [OUT_WIDTH-1:0]       hit_count,
	output logic                       is_file_total,
	output logic                       last_result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

	localparam int WD = MAX_TARGET_LEN + 1;
	localparam int SW = $clog2(WD + 1);
	localparam int LW = $clog2(MAX_TARGET_LEN + 1);

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [OUT_WIDTH-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[OUT_WIDTH-1:0];
	endfunction

	// Configuration registers.
	logic [CFG_DATA_WIDTH-1:0] target_low_q;
	logic [CFG_DATA_WIDTH-1:0] target_high_q;
	logic [LEN_REG_WIDTH-1:0]  target_len_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_low_q  <= '0;
			target_high_q <= '0;
			target_len_q  <= LEN_REG_WIDTH'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_TARGET_LOW:  target_low_q  <= cfg_data;
				REG_TARGET_HIGH: target_high_q <= cfg_data;
				REG_TARGET_LEN:  target_len_q  <= cfg_data[LEN_REG_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       in_take;

	assign in_take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= text_byte;
			end_s1  <= end_of_text;
		end
	end

	// Counting state.
	logic [WD-1:0][7:0]     window_q;
	logic [SW-1:0]          seen_q;
	logic                   prev_nl_q;
	logic [COUNT_WIDTH-1:0] para_q;
	logic [COUNT_WIDTH-1:0] para_hits_q;
	logic [COUNT_WIDTH-1:0] file_hits_q;

	logic [LW-1:0] len_eff;
	match_t        match;

	assign len_eff = (target_len_q > LEN_REG_WIDTH'(MAX_TARGET_LEN)) ?
		LW'(MAX_TARGET_LEN) : LW'(target_len_q);

	wwpc_match #(
		.MAX_TARGET_LEN(MAX_TARGET_LEN)
	) u_match (
		.window  (window_q),
		.cur_byte(byte_s1),
		.seen    (seen_q),
		.len     (len_eff),
		.target  ({target_high_q, target_low_q}),
		.match   (match)
	);

	logic                   close_para;
	logic                   emit_close;
	logic                   emit_final;
	logic [COUNT_WIDTH-1:0] ph_next;
	logic [COUNT_WIDTH-1:0] fh_next;
	logic [COUNT_WIDTH-1:0] ph_closed;
	logic [COUNT_WIDTH-1:0] para_closed;
	logic [COUNT_WIDTH-1:0] ph_end;
	logic [COUNT_WIDTH-1:0] fh_end;
	result_t                res_close;
	result_t                res_final;
	result_t                res_total;
	logic                   push0;
	logic                   push1;
	result_t                push_data0;

	// Hits ending before the current byte land in the paragraph before any close;
	// a hit ending on the final byte lands after it.
	always_comb begin
		ph_next     = match.hit_next ? sat_inc(para_hits_q) : para_hits_q;
		fh_next     = match.hit_next ? sat_inc(file_hits_q) : file_hits_q;
		close_para  = (byte_s1 == CHAR_NL) && prev_nl_q;
		emit_close  = close_para && (ph_next != '0);
		ph_closed   = close_para ? '0 : ph_next;
		para_closed = close_para ? sat_inc(para_q) : para_q;
		ph_end      = (end_s1 && match.hit_end) ? sat_inc(ph_closed) : ph_closed;
		fh_end      = (end_s1 && match.hit_end) ? sat_inc(fh_next) : fh_next;
		emit_final  = end_s1 && (ph_end != '0) && !emit_close;

		res_close.paragraph_number = to_out(para_q);
		res_close.hit_count        = to_out(ph_next);
		res_close.is_file_total    = 1'b0;
		res_close.last_result      = !end_s1;

		res_final.paragraph_number = to_out(para_closed);
		res_final.hit_count        = to_out(ph_end);
		res_final.is_file_total    = 1'b0;
		res_final.last_result      = 1'b0;

		res_total.paragraph_number = '0;
		res_total.hit_count        = to_out(fh_end);
		res_total.is_file_total    = 1'b1;
		res_total.last_result      = 1'b1;

		push0 = valid_s1 && (emit_close || end_s1);
		push1 = valid_s1 && end_s1 && (emit_close || emit_final);
		if (emit_close) begin
			push_data0 = res_close;
		end else if (emit_final) begin
			push_data0 = res_final;
		end else begin
			push_data0 = res_total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			seen_q      <= '0;
			prev_nl_q   <= 1'b0;
			para_q      <= COUNT_WIDTH'(1);
			para_hits_q <= '0;
			file_hits_q <= '0;
		end else if (valid_s1) begin
			if (end_s1) begin
				window_q    <= '0;
				seen_q      <= '0;
				prev_nl_q   <= 1'b0;
				para_q      <= COUNT_WIDTH'(1);
				para_hits_q <= '0;
				file_hits_q <= '0;
			end else begin
				window_q    <= {window_q[WD-2:0], byte_s1};
				if (seen_q < SW'(WD)) begin
					seen_q <= SW'(seen_q + 1'b1);
				end
				prev_nl_q   <= (byte_s1 == CHAR_NL);
				para_q      <= para_closed;
				para_hits_q <= ph_closed;
				file_hits_q <= fh_next;
			end
		end
	end

	// Result queue.
	result_t            head;
	logic [FIFO_CW-1:0] fifo_count;
	logic [FIFO_CW:0]   reserved;

	wwpc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (push0),
		.push_data0(push_data0),
		.push1     (push1),
		.push_data1(res_total),
		.pop       (out_ready),
		.head      (head),
		.not_empty (out_valid),
		.count     (fifo_count)
	);

	// Room for two results of the byte in the input stage and two of a new byte.
	assign reserved = (FIFO_CW + 1)'(fifo_count) + (valid_s1 ? (FIFO_CW + 1)'(2) : '0) +
		(FIFO_CW + 1)'(2);
	assign in_ready = (reserved <= (FIFO_CW + 1)'(FIFO_DEPTH));

	assign paragraph_number = head.paragraph_number;
	assign hit_count        = head.hit_count;
	assign is_file_total    = head.is_file_total;
	assign last_result      = head.last_result;

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push1 |-> push0 && end_s1)
		else $error("second result pushed without a first one");

	a_total_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_file_total) |-> (last_result && paragraph_number == '0))
		else $error("file total result is malformed");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && end_s1) |=> (seen_q == '0 && file_hits_q == '0 && !prev_nl_q))
		else $error("state not cleared after the final byte");

endmodule

// ----- test/paragraph_hit_checker.sv -----
// Checker for the whole-word paragraph counter: predicts every result and compares it.
module paragraph_hit_checker import wwpc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [7:0]                 text_byte,
	input  logic                       end_of_text,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [OUT_WIDTH-1:0]       paragraph_number,
	input  logic [OUT_WIDTH-1:0]       hit_count,
	input  logic                       is_file_total,
	input  logic                       last_result,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
	output int unsigned                failures,
	output int unsigned                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW = MAX_TARGET_LEN_DEF + 1;
	localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_TOP = '1;

	logic [63:0] tgt_low;
	logic [63:0] tgt_high;
	logic [4:0]  tgt_len;

	logic [7:0]  win [0:WINDOW-1];
	logic [7:0]  hist [0:WINDOW];
	int unsigned seen;
	logic        prev_nl;
	logic [15:0] para_no;
	logic [15:0] para_hits;
	logic [15:0] file_hits;

	result_t expected_q[$];

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic [7:0] tgt_byte(input int unsigned i);
		return (i < 8) ? tgt_low[i*8 +: 8] : tgt_high[(i-8)*8 +: 8];
	endfunction

	function automatic logic [15:0] bump(input logic [15:0] v);
		return (v == COUNT_TOP) ? v : v + 16'd1;
	endfunction

	// The window holds the current byte at index 0; off is the index of the candidate's
	// last byte, so off 1 means the current byte is the one after it.
	function automatic logic word_match(input int unsigned avail, input int unsigned len,
		input int unsigned off, input logic after_end);
		int unsigned i;
		if (len == 0 || avail < len + off)
			return 1'b0;
		for (i = 0; i < len; i++) begin
			if (hist[off + len - 1 - i] != tgt_byte(i))
				return 1'b0;
		end
		if (avail > len + off && is_alpha(hist[len + off]))
			return 1'b0;
		if (!after_end && is_alpha(hist[0]))
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic void clear_text_state();
		int i;
		for (i = 0; i < WINDOW; i++)
			win[i] = 8'd0;
		seen = 0;
		prev_nl = 1'b0;
		para_no = 16'd1;
		para_hits = 16'd0;
		file_hits = 16'd0;
	endfunction

	function automatic void add_hit();
		para_hits = bump(para_hits);
		file_hits = bump(file_hits);
	endfunction

	function automatic void queue_result(input logic [15:0] para, input logic [15:0] hits,
		input logic total, input logic closing);
		result_t r;
		r.paragraph_number = para;
		r.hit_count = hits;
		r.is_file_total = total;
		r.last_result = closing;
		expected_q.insert(expected_q.size(), r);
	endfunction

	function automatic void count_byte(input logic [7:0] c, input logic eot);
		int unsigned len;
		int unsigned avail;
		int k;
		logic closed;
		len = (tgt_len > MAX_TARGET_LEN_DEF) ? MAX_TARGET_LEN_DEF : tgt_len;
		avail = seen + 1;
		closed = 1'b0;
		hist[0] = c;
		for (k = 1; k <= WINDOW; k++)
			hist[k] = win[k-1];

		// A match followed by this byte still belongs to the paragraph it sits in.
		if (word_match(avail, len, 1, 1'b0))
			add_hit();

		if (c == CHAR_NL && prev_nl) begin
			if (para_hits != 0) begin
				queue_result(para_no, para_hits, 1'b0, !eot);
				closed = 1'b1;
			end
			para_no = bump(para_no);
			para_hits = 16'd0;
		end
		prev_nl = (c == CHAR_NL);

		if (eot) begin
			if (word_match(avail, len, 0, 1'b1))
				add_hit();
			// When a close was reported on this same byte, the last paragraph is not.
			if (para_hits != 0 && !closed)
				queue_result(para_no, para_hits, 1'b0, 1'b0);
			queue_result(16'd0, file_hits, 1'b1, 1'b1);
			clear_text_state();
		end else begin
			for (k = WINDOW - 1; k > 0; k--)
				win[k] = win[k-1];
			win[0] = c;
			if (seen < WINDOW)
				seen++;
		end
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	task automatic compare_result();
		result_t want;
		if (expected_q.size() == 0) begin
			$error("result with nothing expected: paragraph_number %0d, hit_count %0d",
				paragraph_number, hit_count);
			failures++;
		end else begin
			want = expected_q.pop_front();
			check_field("paragraph_number", 32'(want.paragraph_number),
				32'(paragraph_number));
			check_field("hit_count", 32'(want.hit_count), 32'(hit_count));
			check_field("is_file_total", 32'(want.is_file_total), 32'(is_file_total));
			check_field("last_result", 32'(want.last_result), 32'(last_result));
		end
	endtask

	// Outputs are checked against the queue before the new byte's expected results are added.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_low = '0;
			tgt_high = '0;
			tgt_len = 5'd1;
			clear_text_state();
			expected_q.delete();
			failures = 0;
		end else begin
			if (out_valid && out_ready)
				compare_result();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TARGET_LOW: begin
						tgt_low = cfg_data;
					end
					REG_TARGET_HIGH: begin
						tgt_high = cfg_data;
					end
					REG_TARGET_LEN: begin
						tgt_len = cfg_data[LEN_REG_WIDTH-1:0];
					end
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready)
				count_byte(text_byte, end_of_text);
		end
		pending = expected_q.size();
	end

endmodule

// ----- test/testbench.sv -----
// Top of the counter testbench: clock, reset, text stimulus, watchdog and verdict.
module testbench import wwpc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SEGMENTS       = 20;
	localparam int SEGMENT_BYTES  = 30;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [7:0]                 text_byte;
	logic                       end_of_text;
	logic                       out_valid;
	logic                       out_ready;
	logic [OUT_WIDTH-1:0]       paragraph_number;
	logic [OUT_WIDTH-1:0]       hit_count;
	logic                       is_file_total;
	logic                       last_result;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data;
	int unsigned                failures;
	int unsigned                pending;

	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned seg_bytes = 0;
	logic [7:0]  tgt [0:TARGET_BYTES-1];
	int unsigned tgt_used;
	logic [7:0]  text_q[$];

	whole_word_paragraph_counter_unit uut (.*);

	paragraph_hit_checker hit_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: random stalls, plus a long hold-off when one is requested.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [63:0] pack_text(input string s, input int first);
		logic [63:0] w;
		int i;
		w = '0;
		for (i = 0; i < 8; i++) begin
			if (first + i < s.len())
				w[i*8 +: 8] = s[first + i];
		end
		return w;
	endfunction

	function automatic logic [7:0] pick_letter();
		case ($urandom_range(0, 4))
			0: return "a";
			1: return "A";
			2: return "z";
			3: return "Z";
			default: return "b";
		endcase
	endfunction

	// Includes the bytes right next to the letter ranges.
	function automatic logic [7:0] pick_separator();
		case ($urandom_range(0, 6))
			0: return " ";
			1: return ".";
			2: return "-";
			3: return "@";
			4: return "[";
			5: return 8'h60;
			default: return "{";
		endcase
	endfunction

	function automatic logic [7:0] pick_target_char();
		if ($urandom_range(0, 23) == 0)
			return CHAR_NL;
		return $urandom_range(0, 1) ? pick_letter() : pick_separator();
	endfunction

	task automatic add_byte(input logic [7:0] c);
		text_q.insert(text_q.size(), c);
	endtask

	task automatic add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_target(input int unsigned n);
		int unsigned i;
		if (n == 0)
			add_byte(pick_separator());
		for (i = 0; i < n; i++)
			add_byte(tgt[i]);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_target(input logic [63:0] lo, input logic [63:0] hi,
		input logic [4:0] len);
		int i;
		for (i = 0; i < 8; i++) begin
			tgt[i] = lo[i*8 +: 8];
			tgt[i+8] = hi[i*8 +: 8];
		end
		tgt_used = (len > MAX_TARGET_LEN_DEF) ? MAX_TARGET_LEN_DEF : len;
		write_reg(REG_TARGET_LOW, lo);
		write_reg(REG_TARGET_HIGH, hi);
		write_reg(REG_TARGET_LEN, {{(CFG_DATA_WIDTH-LEN_REG_WIDTH){1'b0}}, len});
		cfg_valid <= 1'b0;
	endtask

	task automatic random_target();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  len;
		int i;
		int unsigned r;
		for (i = 0; i < 8; i++) begin
			lo[i*8 +: 8] = pick_target_char();
			hi[i*8 +: 8] = pick_target_char();
		end
		r = $urandom_range(0, 19);
		if (r == 0)
			len = 5'd0;
		else if (r == 1)
			len = 5'($urandom_range(17, 31));
		else if (r < 6)
			len = 5'($urandom_range(5, 16));
		else
			len = 5'($urandom_range(1, 4));
		program_target(lo, hi, len);
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction, with
	// valid still high so that the next call either replaces the payload or drops valid.
	task automatic send_byte(input logic [7:0] c, input logic eot);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= c;
		end_of_text <= eot;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_text();
		int i;
		if (text_q.size() == 0)
			add_byte(pick_separator());
		for (i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1);
		seg_bytes += text_q.size();
		text_q.delete();
	endtask

	// Mostly text built around the target, with some texts of raw noise.
	task automatic build_text();
		int n;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 8);
			repeat (n) add_byte(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(2, 12);
			repeat (n) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						add_target(tgt_used);
					end
					4: begin
						repeat ($urandom_range(1, 3)) add_byte(pick_letter());
					end
					5: begin
						add_byte(pick_separator());
					end
					6: begin
						add_byte(CHAR_NL);
						add_byte(CHAR_NL);
					end
					7: begin
						add_byte(CHAR_NL);
					end
					8: begin
						add_byte(8'($urandom_range(0, 255)));
					end
					default: begin
						add_target((tgt_used > 1) ? $urandom_range(1, tgt_used - 1) : 0);
					end
				endcase
			end
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int unsigned seg;
		arst_n = 1'b0;
		in_valid = 1'b0;
		text_byte = 8'd0;
		end_of_text = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TARGET_LOW;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Matches at the start, after a zero byte, before a newline pair, before an all-ones
		// byte and at the end; the third newline closes an empty paragraph.
		program_target(pack_text("ab", 0), '0, 5'd2);
		add_text("ab ");
		add_byte(8'h00);
		add_text("ab\n\n\nab");
		add_byte(8'hFF);
		add_text("ab");
		send_text();
		settle();

		// Zero length never matches.
		program_target('1, '1, 5'd0);
		add_byte(8'hFF);
		add_byte(8'hFF);
		send_text();
		settle();

		// Length beyond the maximum is clipped; the whole text is one full-width match.
		program_target(pack_text("0123456789:;<=>?", 0), pack_text("0123456789:;<=>?", 8), 5'd31);
		add_text("0123456789:;<=>?");
		send_text();
		settle();

		// Newline target: a close and a hit in the last paragraph on the same final byte.
		program_target(pack_text("\n", 0), '0, 5'd1);
		add_text(" \n\n");
		send_text();
		settle();

		for (seg = 0; seg < SEGMENTS; seg++) begin
			case (seg % 4)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 48;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 48;
				end
				default: begin
					gap_pct = 18;
					stall_pct = 18;
				end
			endcase
			random_target();
			if (seg % 8 == 4) begin
				@(posedge clk);
				hold_left = HOLD_CYCLES;
				@(negedge clk);
			end
			seg_bytes = 0;
			// During a hold-off the sender keeps going so that the result queue fills.
			while (seg_bytes < SEGMENT_BYTES || hold_left != 0) begin
				build_text();
				send_text();
			end
			settle();
		end

		if (failures == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
